>>> src/llcp_pkg.sv
// ============================================================================
// llcp_pkg: shared constants for the 3D line-to-line closest point block
// Result field widths, saturation limits, quotient width and queue depth.
// ============================================================================
package llcp_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int NUM_IN_FIELDS   = 12;
  localparam int LIMB_W          = 32;

  localparam int MID_W = 32;
  localparam int GAP_W = 48;
  localparam int OUT_W = 3 * MID_W + GAP_W;

  // Quotient bits kept by each divider; anything larger is flagged as overflow.
  localparam int QB = GAP_W + 1;

  localparam logic [QB-1:0] MID_POS_Q = QB'(64'h0000_0000_7FFF_FFFF);
  localparam logic [QB-1:0] MID_NEG_Q = QB'(64'h0000_0000_8000_0000);
  localparam logic [QB-1:0] GAP_MAX_Q = QB'(64'h0000_FFFF_FFFF_FFFF);

  localparam logic [MID_W-1:0] MID_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [MID_W-1:0] MID_NEG_SAT = 32'h8000_0000;

  localparam int QDEPTH = 4;

endpackage

>>> src/llcp_mul.sv
// ============================================================================
// llcp_mul: pipelined signed multiplier
// Sign-magnitude product built one 32-bit limb row of b per stage.
// ============================================================================
module llcp_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  import llcp_pkg::*;

  localparam int NA  = (AW + 31) / 32;
  localparam int NB  = (BW + 31) / 32;
  localparam int ACW = LIMB_W * (NA + NB);

  logic [AW-1:0]          ua;
  logic [BW-1:0]          ub;
  logic [LIMB_W*NA-1:0]   ma_r [NB];
  logic [LIMB_W*NB-1:0]   mb_r [NB];
  logic                   sg_r [NB+2];
  logic [2*LIMB_W-1:0]    pp_r [NB][NA];
  logic [ACW-1:0]         acc_r [NB];
  logic signed [AW+BW-1:0] p_r;

  assign ua = a[AW-1] ? AW'(-a) : AW'(a);
  assign ub = b[BW-1] ? BW'(-b) : BW'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r[0] <= (LIMB_W*NA)'(ua);
      mb_r[0] <= (LIMB_W*NB)'(ub);
      sg_r[0] <= a[AW-1] ^ b[BW-1];
      sg_r[NB+1] <= sg_r[NB];
      p_r <= sg_r[NB+1] ? (AW+BW)'(ACW'(0) - acc_r[NB-1]) : (AW+BW)'(acc_r[NB-1]);
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_row
    logic [ACW-1:0] row_e;
    logic [ACW-1:0] row_o;

    // Even and odd limb products do not overlap, so each half is a plain OR.
    always_comb begin
      row_e = '0;
      row_o = '0;
      for (int j = 0; j < NA; j++) begin
        if (j % 2 == 0) row_e = row_e | (ACW'(pp_r[k][j]) << (LIMB_W * (j + k)));
        else            row_o = row_o | (ACW'(pp_r[k][j]) << (LIMB_W * (j + k)));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < NA; j++) begin
          pp_r[k][j] <= ma_r[k][LIMB_W*j +: LIMB_W] * mb_r[k][LIMB_W*k +: LIMB_W];
        end
        sg_r[k+1] <= sg_r[k];
      end
    end

    if (k + 1 < NB) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          ma_r[k+1] <= ma_r[k];
          mb_r[k+1] <= mb_r[k];
        end
      end
    end

    if (k == 0) begin : g_acc0
      always_ff @(posedge clk) begin
        if (en) acc_r[0] <= row_e + row_o;
      end
    end else begin : g_accn
      always_ff @(posedge clk) begin
        if (en) acc_r[k] <= acc_r[k-1] + row_e + row_o;
      end
    end
  end

  assign p = p_r;

endmodule

>>> src/llcp_div.sv
// ============================================================================
// llcp_div: pipelined unsigned restoring divider
// One quotient bit per stage after a first stage that flags overflow.
// ============================================================================
module llcp_div #(
  parameter int NWID = 64,
  parameter int DWID = 32,
  parameter int QBITS = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NWID-1:0]  n,
  input  logic [DWID-1:0]  d,
  output logic [QBITS-1:0] q,
  output logic             ovf
);
  localparam int RW = (NWID > DWID + QBITS) ? NWID : DWID + QBITS;

  logic [RW-1:0]    r_r   [QBITS];
  logic [DWID-1:0]  d_r   [QBITS];
  logic [QBITS-1:0] q_r   [QBITS+1];
  logic             ovf_r [QBITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= RW'(n);
      d_r[0]   <= d;
      q_r[0]   <= '0;
      ovf_r[0] <= RW'(n) >= (RW'(d) << QBITS);
    end
  end

  for (genvar i = 1; i <= QBITS; i++) begin : g_stage
    logic [RW-1:0] sh;
    logic          ge;

    assign sh = RW'(d_r[i-1]) << (QBITS - i);
    assign ge = r_r[i-1] >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i]   <= q_r[i-1] | (QBITS'(ge) << (QBITS - i));
        ovf_r[i] <= ovf_r[i-1];
      end
    end

    if (i < QBITS) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[i] <= ge ? r_r[i-1] - sh : r_r[i-1];
          d_r[i] <= d_r[i-1];
        end
      end
    end
  end

  assign q   = q_r[QBITS];
  assign ovf = ovf_r[QBITS];

endmodule

>>> src/llcp_dly.sv
// ============================================================================
// llcp_dly: enabled delay line
// Carries side data alongside a pipelined arithmetic unit.
// ============================================================================
module llcp_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[N-1];

endmodule

>>> src/llcp_front.sv
// ============================================================================
// llcp_front: input pipeline
// Forms the dot products, denominator, numerators and triple product,
// and classifies each word as degenerate when the denominator is zero.
// ============================================================================
module llcp_front #(
  parameter int CW = llcp_pkg::COORD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [12*CW-1:0]          in_data,
  input  logic                      q_full,
  output logic                      push,
  output logic signed [4*CW+6:0]    den,
  output logic signed [4*CW+6:0]    num_a,
  output logic signed [4*CW+6:0]    num_b,
  output logic signed [3*CW+3:0]    tp,
  output logic                      dz,
  output logic [9*CW+2:0]           suv
);
  import llcp_pkg::*;

  localparam int DW    = 2 * CW + 3;
  localparam int NW    = 2 * DW + 1;
  localparam int TW    = 3 * CW + 4;
  localparam int PRW   = 2 * CW + 2;
  localparam int SUV_W = 9 * CW + 3;
  localparam int LAT1  = (DW + 31) / 32 + 3;
  localparam int NSTG  = LAT1 + 5;

  logic [NSTG-1:0] vld_r;
  logic            en;

  logic signed [CW-1:0] pa_r [3], ua_r [3], pb_r [3], vb_r [3];
  logic signed [CW:0]   w1_r [3], s1_r [3];
  logic signed [CW-1:0] u1_r [3], v1_r [3];
  logic signed [PRW-1:0] pwu_r [3], puu_r [3], pvu_r [3], pwv_r [3], pvv_r [3];
  logic signed [PRW-1:0] cx_r [3], cy_r [3];
  logic signed [CW:0]   w2_r [3];
  logic [SUV_W-1:0]     suv2_r;
  logic [SUV_W-1:0]     suv_d;
  logic signed [DW-1:0] wu_r, uu_r, vu_r, wv_r, vv_r;
  logic signed [DW-1:0] n_r [3], w3_r [3];
  logic signed [2*DW-1:0] pd1, pd2, pa1, pa2, pb1, pb2;
  logic signed [2*DW-1:0] pt [3];

  logic signed [NW-1:0] den_r, na_r, nb_r;
  logic signed [TW-1:0] t_r;
  logic                 dz_r;
  logic [SUV_W-1:0]     suv_r;

  assign en       = !(vld_r[NSTG-1] && q_full);
  assign in_ready = en;
  assign push     = vld_r[NSTG-1] && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        pa_r[c] <= in_data[CW*c +: CW];
        ua_r[c] <= in_data[CW*(3+c) +: CW];
        pb_r[c] <= in_data[CW*(6+c) +: CW];
        vb_r[c] <= in_data[CW*(9+c) +: CW];

        w1_r[c] <= (CW+1)'(pa_r[c]) - (CW+1)'(pb_r[c]);
        s1_r[c] <= (CW+1)'(pa_r[c]) + (CW+1)'(pb_r[c]);
        u1_r[c] <= ua_r[c];
        v1_r[c] <= vb_r[c];

        pwu_r[c] <= PRW'(w1_r[c]) * PRW'(u1_r[c]);
        puu_r[c] <= PRW'(u1_r[c]) * PRW'(u1_r[c]);
        pvu_r[c] <= PRW'(v1_r[c]) * PRW'(u1_r[c]);
        pwv_r[c] <= PRW'(w1_r[c]) * PRW'(v1_r[c]);
        pvv_r[c] <= PRW'(v1_r[c]) * PRW'(v1_r[c]);
        cx_r[c]  <= PRW'(u1_r[(c+1)%3]) * PRW'(v1_r[(c+2)%3]);
        cy_r[c]  <= PRW'(u1_r[(c+2)%3]) * PRW'(v1_r[(c+1)%3]);
        w2_r[c]  <= w1_r[c];

        n_r[c]  <= DW'(cx_r[c]) - DW'(cy_r[c]);
        w3_r[c] <= DW'(w2_r[c]);
        suv2_r[(CW+1)*c +: CW+1]        <= s1_r[c];
        suv2_r[3*(CW+1)+CW*c +: CW]     <= u1_r[c];
        suv2_r[3*(CW+1)+3*CW+CW*c +: CW] <= v1_r[c];
      end
      wu_r <= DW'(pwu_r[0]) + DW'(pwu_r[1]) + DW'(pwu_r[2]);
      uu_r <= DW'(puu_r[0]) + DW'(puu_r[1]) + DW'(puu_r[2]);
      vu_r <= DW'(pvu_r[0]) + DW'(pvu_r[1]) + DW'(pvu_r[2]);
      wv_r <= DW'(pwv_r[0]) + DW'(pwv_r[1]) + DW'(pwv_r[2]);
      vv_r <= DW'(pvv_r[0]) + DW'(pvv_r[1]) + DW'(pvv_r[2]);

      den_r <= NW'(pd1) - NW'(pd2);
      na_r  <= NW'(pa1) - NW'(pa2);
      nb_r  <= NW'(pb1) - NW'(pb2);
      t_r   <= TW'(pt[0]) + TW'(pt[1]) + TW'(pt[2]);
      dz_r  <= (pd1 == pd2);
      suv_r <= suv_d;
    end
  end

  llcp_mul #(.AW(DW), .BW(DW)) u_m_d1 (.clk, .en, .a(uu_r), .b(vv_r), .p(pd1));
  llcp_mul #(.AW(DW), .BW(DW)) u_m_d2 (.clk, .en, .a(vu_r), .b(vu_r), .p(pd2));
  llcp_mul #(.AW(DW), .BW(DW)) u_m_a1 (.clk, .en, .a(wv_r), .b(vu_r), .p(pa1));
  llcp_mul #(.AW(DW), .BW(DW)) u_m_a2 (.clk, .en, .a(wu_r), .b(vv_r), .p(pa2));
  llcp_mul #(.AW(DW), .BW(DW)) u_m_b1 (.clk, .en, .a(wv_r), .b(uu_r), .p(pb1));
  llcp_mul #(.AW(DW), .BW(DW)) u_m_b2 (.clk, .en, .a(wu_r), .b(vu_r), .p(pb2));

  for (genvar c = 0; c < 3; c++) begin : g_tp
    llcp_mul #(.AW(DW), .BW(DW)) u_m_t (.clk, .en, .a(w3_r[c]), .b(n_r[c]), .p(pt[c]));
  end

  llcp_dly #(.W(SUV_W), .N(LAT1 + 1)) u_dly_suv (.clk, .en, .d(suv2_r), .q(suv_d));

  assign den   = den_r;
  assign num_a = na_r;
  assign num_b = nb_r;
  assign tp    = t_r;
  assign dz    = dz_r;
  assign suv   = suv_r;

endmodule

>>> src/llcp_back.sv
// ============================================================================
// llcp_back: solve and output pipeline
// Scales the numerators, divides by twice the denominator, rounds,
// saturates and holds the result word until it is taken.
// ============================================================================
module llcp_back #(
  parameter int CW = llcp_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic signed [4*CW+6:0]        den,
  input  logic signed [4*CW+6:0]        num_a,
  input  logic signed [4*CW+6:0]        num_b,
  input  logic signed [3*CW+3:0]        tp,
  input  logic                          dz,
  input  logic [9*CW+2:0]               suv,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [llcp_pkg::OUT_W-1:0]    out_data,
  output logic                          out_degen
);
  import llcp_pkg::*;

  localparam int DW    = 2 * CW + 3;
  localparam int NW    = 2 * DW + 1;
  localparam int TW    = 3 * CW + 4;
  localparam int MW    = NW + CW + 3;
  localparam int GW    = 2 * TW + 1;
  localparam int LAT2  = (NW + 31) / 32 + 3;
  localparam int NSTG  = LAT2 + QB + 5;

  logic [NSTG-1:0] vld_r;
  logic            en;

  logic signed [NW-1:0] den0_r, na0_r, nb0_r, t0_r;
  logic signed [NW-1:0] s0_r [3], u0_r [3], v0_r [3];
  logic                 dz0_r;

  logic signed [2*NW-1:0] ps [3], pna [3], pnb [3];
  logic signed [2*NW-1:0] ptt;
  logic [NW:0]            dd_d;

  logic signed [MW-1:0] num2_r [3];
  logic [GW-1:0]        gn2_r;
  logic signed [NW-1:0] den2_r;
  logic                 dz2_r;

  logic [MW:0]   mag3_r [3];
  logic          neg3_r [3];
  logic [GW-1:0] gn3_r;
  logic [NW:0]   dd3_r;
  logic          dz3_r;

  logic [QB-1:0] qm [3];
  logic          ovm [3];
  logic [QB-1:0] qg;
  logic          ovg;
  logic [3:0]    flg_d;

  logic             sat [3];
  logic [MID_W-1:0] mag [3];
  logic [MID_W-1:0] mid [3];
  logic [GAP_W-1:0] gap;

  logic [OUT_W-1:0] out_data_r;
  logic             out_degen_r;

  assign en        = !vld_r[NSTG-1] || out_ready;
  assign q_ready   = en;
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den0_r <= den;
      na0_r  <= num_a;
      nb0_r  <= num_b;
      t0_r   <= NW'(tp);
      dz0_r  <= dz;
      for (int c = 0; c < 3; c++) begin
        s0_r[c] <= NW'($signed(suv[(CW+1)*c +: CW+1]));
        u0_r[c] <= NW'($signed(suv[3*(CW+1)+CW*c +: CW]));
        v0_r[c] <= NW'($signed(suv[3*(CW+1)+3*CW+CW*c +: CW]));
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_mid
    llcp_mul #(.AW(NW), .BW(NW)) u_m_s (.clk, .en, .a(s0_r[c]), .b(den0_r), .p(ps[c]));
    llcp_mul #(.AW(NW), .BW(NW)) u_m_a (.clk, .en, .a(na0_r), .b(u0_r[c]), .p(pna[c]));
    llcp_mul #(.AW(NW), .BW(NW)) u_m_b (.clk, .en, .a(nb0_r), .b(v0_r[c]), .p(pnb[c]));

    llcp_div #(.NWID(MW + 1), .DWID(NW + 1), .QBITS(QB)) u_div (
      .clk, .en, .n(mag3_r[c]), .d(dd3_r), .q(qm[c]), .ovf(ovm[c])
    );
  end

  llcp_mul #(.AW(NW), .BW(NW)) u_m_tt (.clk, .en, .a(t0_r), .b(t0_r), .p(ptt));

  llcp_dly #(.W(NW + 1), .N(LAT2)) u_dly_den (
    .clk, .en, .d({den0_r, dz0_r}), .q(dd_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        num2_r[c] <= MW'(ps[c]) + MW'(pna[c]) + MW'(pnb[c]);
      end
      den2_r <= $signed(dd_d[NW:1]);
      dz2_r  <= dd_d[0];
      gn2_r  <= (GW'(ptt) << 1) + GW'($signed(dd_d[NW:1]));

      // Round half away from zero: (|num| + den) / (2 den) on the magnitude.
      for (int c = 0; c < 3; c++) begin
        neg3_r[c] <= num2_r[c][MW-1];
        mag3_r[c] <= num2_r[c][MW-1] ? (MW+1)'(den2_r) - (MW+1)'(num2_r[c])
                                    : (MW+1)'(num2_r[c]) + (MW+1)'(den2_r);
      end
      gn3_r <= gn2_r;
      dd3_r <= {den2_r, 1'b0};
      dz3_r <= dz2_r;
    end
  end

  llcp_div #(.NWID(GW), .DWID(NW + 1), .QBITS(QB)) u_div_gap (
    .clk, .en, .n(gn3_r), .d(dd3_r), .q(qg), .ovf(ovg)
  );

  llcp_dly #(.W(4), .N(QB + 1)) u_dly_flg (
    .clk, .en, .d({neg3_r[2], neg3_r[1], neg3_r[0], dz3_r}), .q(flg_d)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sat[c] = ovm[c] || (flg_d[c+1] ? (qm[c] > MID_NEG_Q) : (qm[c] > MID_POS_Q));
      mag[c] = sat[c] ? (flg_d[c+1] ? MID_NEG_SAT : MID_POS_SAT) : qm[c][MID_W-1:0];
      mid[c] = flg_d[c+1] ? MID_W'(0) - mag[c] : mag[c];
    end
    gap = (ovg || (qg > GAP_MAX_Q)) ? GAP_MAX_Q[GAP_W-1:0] : qg[GAP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_degen_r <= flg_d[0];
      out_data_r  <= flg_d[0] ? '0 : {gap, mid[2], mid[1], mid[0]};
    end
  end

  assign out_data  = out_data_r;
  assign out_degen = out_degen_r;

endmodule

>>> src/line_line_closest_point_3d.sv
// ============================================================================
// line_line_closest_point_3d: closest approach of two lines in 3D
// Midpoint of the shortest joining segment and its squared length.
// ============================================================================
// The delay from accepting an input word to out_tvalid grows with the limb
//   count of the wide multipliers.
// Throughput: one word per cycle while the output is not stalled, set by the fully
//   pipelined multipliers and the 50-stage dividers, each taking a new operand every enabled cycle.
// Reset clears the valid bits of both pipelines and the queue; the data
//   registers are not reset and no clearing pass is needed.
module line_line_closest_point_3d #(
  parameter int COORD_WIDTH = llcp_pkg::COORD_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // start_a_x, start_a_y, start_a_z, dir_a_x, dir_a_y, dir_a_z,
  // start_b_x, start_b_y, start_b_z, dir_b_x, dir_b_y, dir_b_z (low to high)
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]        in_tdata,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // mid_x, mid_y, mid_z, gap_squared (low to high)
  output logic [llcp_pkg::OUT_W-1:0]                 out_tdata,
  // degenerate
  output logic [0:0]                                 out_tuser
);
  import llcp_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = 2 * CW + 3;
  localparam int NW    = 2 * DW + 1;
  localparam int TW    = 3 * CW + 4;
  localparam int SUV_W = 9 * CW + 3;
  localparam int EW    = 3 * NW + TW + 1 + SUV_W;
  localparam int QAW   = $clog2(QDEPTH);

  // The front half computes everything up to the denominator and flags
  // degenerate pairs; the back half does the scaling and the divisions.
  // A short queue between them lets the front keep taking words while the
  // back waits on the output.
  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_ready;
  logic signed [NW-1:0] f_den, f_na, f_nb;
  logic signed [TW-1:0] f_tp;
  logic                 f_dz;
  logic [SUV_W-1:0]     f_suv;
  logic [EW-1:0]        q_wdata;
  logic [EW-1:0]        q_rdata;

  logic [EW-1:0]  q_mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  llcp_front #(.CW(CW)) u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata[12*CW-1:0]),
    .q_full,
    .push,
    .den      (f_den),
    .num_a    (f_na),
    .num_b    (f_nb),
    .tp       (f_tp),
    .dz       (f_dz),
    .suv      (f_suv)
  );

  assign q_wdata = {f_suv, f_dz, f_tp, f_nb, f_na, f_den};

  // Queue: written at the tail, read at the head, four words deep.
  assign q_full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign pop     = q_valid && q_ready;
  assign cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  assign q_rdata = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= q_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  llcp_back #(.CW(CW)) u_back (
    .clk, .rst_n,
    .q_valid,
    .q_ready,
    .den       ($signed(q_rdata[NW-1:0])),
    .num_a     ($signed(q_rdata[2*NW-1:NW])),
    .num_b     ($signed(q_rdata[3*NW-1:2*NW])),
    .tp        ($signed(q_rdata[3*NW+TW-1:3*NW])),
    .dz        (q_rdata[3*NW+TW]),
    .suv       (q_rdata[EW-1:3*NW+TW+1]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_degen (out_tuser[0])
  );

  // The queue never holds more words than it has entries.
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("queue count above depth");

  // The front never hands over a word while the queue is full.
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("push into full queue");

  // The input side only stalls when the queue is full.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_full)
    else $error("input stalled with room in queue");

  // A degenerate result carries all-zero data.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("degenerate result with nonzero data");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: regression bench for the 3D line-to-line closest point block
// Sends pairs of lines through the stream input, predicts each result word
// with exact wide integer arithmetic and checks every result word field by
// field, under several sender and receiver idling patterns.
// ============================================================================
module tb_top;
  import llcp_pkg::*;

  localparam int CW     = COORD_WIDTH_DEF;
  localparam int IN_W   = ((12 * CW + 7) / 8) * 8;
  localparam int LATENCY = 71;

  typedef logic signed [255:0] exact_t;

  // One result word as the block reports it.
  typedef struct packed {
    logic [MID_W-1:0] mid_x;
    logic [MID_W-1:0] mid_y;
    logic [MID_W-1:0] mid_z;
    logic [GAP_W-1:0] gap_squared;
    logic             degenerate;
  } closest_t;

  logic            clk;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  // start_a_x..z, dir_a_x..z, start_b_x..z, dir_b_x..z (low to high)
  logic [IN_W-1:0] in_tdata;
  logic            out_tvalid;
  logic            out_tready;
  // mid_x, mid_y, mid_z, gap_squared (low to high)
  logic [OUT_W-1:0] out_tdata;
  // degenerate
  logic [0:0]      out_tuser;

  // Expected results in the order their input words were accepted.
  closest_t expected_q[$];
  int       error_count;

  // Idling knobs, in percent, and the long receiver hold-off request.
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off_req;
  int hold_off_left;

  line_line_closest_point_3d u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Closest approach computed exactly. The midpoint and the squared gap are
  // rational numbers over the denominator D; adding half the divisor before
  // dividing the magnitude rounds halfway cases away from zero.
  function automatic closest_t predict_closest(input logic [IN_W-1:0] d);
    exact_t   pa[3], pb[3], u[3], v[3], w[3], s[3], n[3];
    exact_t   wu, uu, vu, wv, vv, den, num_a, num_b, num, mag, q, t;
    logic     neg;
    closest_t r;
    for (int c = 0; c < 3; c++) begin
      pa[c] = $signed(d[c * CW +: CW]);
      u[c]  = $signed(d[(3 + c) * CW +: CW]);
      pb[c] = $signed(d[(6 + c) * CW +: CW]);
      v[c]  = $signed(d[(9 + c) * CW +: CW]);
      w[c]  = pa[c] - pb[c];
      s[c]  = pa[c] + pb[c];
    end
    wu  = w[0] * u[0] + w[1] * u[1] + w[2] * u[2];
    uu  = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    vu  = v[0] * u[0] + v[1] * u[1] + v[2] * u[2];
    wv  = w[0] * v[0] + w[1] * v[1] + w[2] * v[2];
    vv  = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    den = uu * vv - vu * vu;
    r = '0;
    if (den == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    num_a = wv * vu - wu * vv;
    num_b = wv * uu - wu * vu;
    for (int c = 0; c < 3; c++) begin
      num = s[c] * den + num_a * u[c] + num_b * v[c];
      neg = num < 0;
      mag = neg ? -num : num;
      q   = (mag + den) / (den + den);
      if (neg) begin
        if (q > 256'sd2147483648) q = 256'sd2147483648;
        q = -q;
      end else if (q > 256'sd2147483647) begin
        q = 256'sd2147483647;
      end
      case (c)
        0: r.mid_x = q[MID_W-1:0];
        1: r.mid_y = q[MID_W-1:0];
        default: r.mid_z = q[MID_W-1:0];
      endcase
    end
    n[0] = u[1] * v[2] - u[2] * v[1];
    n[1] = u[2] * v[0] - u[0] * v[2];
    n[2] = u[0] * v[1] - u[1] * v[0];
    t = w[0] * n[0] + w[1] * n[1] + w[2] * n[2];
    t = t * t;
    q = (t + t + den) / (den + den);
    if (q > 256'sd281474976710655) q = 256'sd281474976710655;
    r.gap_squared = q[GAP_W-1:0];
    return r;
  endfunction

  // Predict on every accepted input word and check every accepted result.
  always @(posedge clk) begin
    closest_t got, want;
    if (rst_n && in_tvalid && in_tready) expected_q.push_back(predict_closest(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[MID_W-1:0], out_tdata[2*MID_W-1:MID_W],
             out_tdata[3*MID_W-1:2*MID_W], out_tdata[OUT_W-1:3*MID_W], out_tuser[0]};
      if (expected_q.size() == 0) begin
        $error("result word with no input pending");
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.mid_x !== want.mid_x) begin
          $error("mid_x expected %h actual %h", want.mid_x, got.mid_x);
          error_count++;
        end
        if (got.mid_y !== want.mid_y) begin
          $error("mid_y expected %h actual %h", want.mid_y, got.mid_y);
          error_count++;
        end
        if (got.mid_z !== want.mid_z) begin
          $error("mid_z expected %h actual %h", want.mid_z, got.mid_z);
          error_count++;
        end
        if (got.gap_squared !== want.gap_squared) begin
          $error("gap_squared expected %h actual %h", want.gap_squared, got.gap_squared);
          error_count++;
        end
        if (got.degenerate !== want.degenerate) begin
          $error("degenerate expected %b actual %b", want.degenerate, got.degenerate);
          error_count++;
        end
      end
    end
  end

  // Receiver: random stalls, or a long counted hold-off when requested.
  always @(negedge clk) begin
    if (hold_off_req && hold_off_left == 0) hold_off_left = 400;
    if (hold_off_left > 0) begin
      out_tready = 1'b0;
      hold_off_left--;
      if (hold_off_left == 0) hold_off_req = 1'b0;
    end else begin
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one word; returns at the falling edge after it was taken, with
  // tvalid still high so back-to-back words need no extra edge.
  task automatic send_word(input logic [IN_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = word;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord(input int kind);
    case (kind)
      0: return CW'($urandom_range(600)) - CW'(300);
      1: return CW'($urandom_range(200000)) - CW'(100000);
      2: return CW'($urandom);
      default: return $urandom_range(1) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endcase
  endfunction

  // Random line pair: mostly ordinary geometry, with parallel, zero-direction
  // and full-range pairs mixed in.
  function automatic logic [IN_W-1:0] random_pair();
    logic [IN_W-1:0] d;
    int kind, shape, k;
    kind  = $urandom_range(3) == 3 ? ($urandom_range(1) ? 2 : 3) : $urandom_range(1);
    shape = $urandom_range(9);
    for (int f = 0; f < 12; f++) d[f * CW +: CW] = rand_coord(kind);
    if (shape == 0) begin
      k = $urandom_range(6) - 3;
      for (int c = 0; c < 3; c++) d[(9 + c) * CW +: CW] = CW'(k) * d[(3 + c) * CW +: CW];
    end else if (shape == 1) begin
      d[($urandom_range(1) ? 3 : 9) * CW +: 3 * CW] = '0;
    end else if (shape == 2) begin
      for (int c = 0; c < 3; c++) d[(3 + c) * CW +: CW] = CW'($urandom_range(4)) - CW'(2);
    end
    return d;
  endfunction

  function automatic logic [IN_W-1:0] make_pair(input logic [CW-1:0] f[12]);
    logic [IN_W-1:0] d;
    for (int i = 0; i < 12; i++) d[i * CW +: CW] = f[i];
    return d;
  endfunction

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  // Corner geometry: skew lines, intersecting lines, parallel lines, zero
  // directions, and field extremes that drive the results into saturation.
  task automatic test_directed();
    logic [CW-1:0] f[12];
    logic [CW-1:0] mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    f = '{0, 0, 0, 256, 0, 0, 0, 0, 256, 0, 256, 0};
    send_word(make_pair(f));
    f = '{0, 0, 0, 256, 0, 0, 0, 0, 0, 0, 256, 0};
    send_word(make_pair(f));
    f = '{0, 0, 0, 256, 256, 0, 512, 512, 0, -512, -512, 0};
    send_word(make_pair(f));
    f = '{0, 0, 0, 0, 0, 0, 5, 7, 9, 1, 2, 3};
    send_word(make_pair(f));
    f = '{1, 2, 3, 0, 0, 0, 5, 7, 9, 0, 0, 0};
    send_word(make_pair(f));
    f = '{1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0};
    send_word(make_pair(f));
    f = '{1, 1, 1, 3, 0, 0, 0, 0, 0, 0, 3, 0};
    send_word(make_pair(f));
    f = '{mx, mx, mx, 1, 0, 0, mn, mn, mn, 0, 1, 0};
    send_word(make_pair(f));
    f = '{mn, mn, mn, mx, 1, 0, mx, mx, mx, 1, mx, 0};
    send_word(make_pair(f));
    f = '{mx, mn, mx, mn, mx, mn, mn, mx, mn, mx, mn, 1};
    send_word(make_pair(f));
    f = '{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx};
    send_word(make_pair(f));
    f = '{mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn};
    send_word(make_pair(f));
    f = '{0, mx, 0, mx, 0, mn, mn, 0, mx, 0, mn, mx};
    send_word(make_pair(f));
    f = '{-1, -1, -1, -1, 1, -1, 1, 1, 1, 1, -1, 1};
    send_word(make_pair(f));
    for (int i = 0; i < 6; i++) send_word({IN_W{1'b1}} ^ (IN_W'(1) << (i * 48 + 7)));
    send_word('0);
    in_tvalid = 1'b0;
    wait_drained();
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_word(random_pair());
    in_tvalid = 1'b0;
    wait_drained();
  endtask

  // The receiver holds off long enough for the block to fill up and push
  // back on its input while words keep being offered.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b1;
    for (int i = 0; i < 150; i++) send_word(random_pair());
    in_tvalid = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b0;
    hold_off_left  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random(300, 0, 0);
    test_random(300, 60, 0);
    test_random(300, 0, 60);
    test_random(300, 21, 21);
    test_backpressure();
    if (error_count == 0) begin
      $display("line_line_closest_point_3d regression: pass");
    end else begin
      $display("line_line_closest_point_3d regression: fail");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("line_line_closest_point_3d regression: fail");
    $finish;
  end

endmodule

>>> line_line_closest_point_3d.f
src/llcp_pkg.sv
src/llcp_mul.sv
src/llcp_div.sv
src/llcp_dly.sv
src/llcp_front.sv
src/llcp_back.sv
src/line_line_closest_point_3d.sv
test/tb_top.sv
